FILE: hdl/macd_crossover_signal_unit_defines.svh
// Assertion macros shared by the verification code of the MACD crossover unit.
`ifndef MACD_CROSSOVER_SIGNAL_UNIT_DEFINES_SVH
`define MACD_CROSSOVER_SIGNAL_UNIT_DEFINES_SVH

// Check a property at every rising clock edge outside reset.
`define MCS_ASSERT_NOW(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mcs_pkg.sv
// Types and constants of the MACD crossover signal unit.
package mcs_pkg;

  localparam int PriceW    = 32;
  localparam int DayW      = 32;
  localparam int MaxPosW   = 10;
  localparam int PosW      = 11;
  localparam int AmountW   = 42;
  localparam int ActionW   = 3;
  localparam int AvgW      = 48;
  localparam int PriceShift = 8;
  localparam int MulW      = 32;
  localparam int ProdW     = 2 * MulW;
  localparam int AccW      = AvgW + MulW;

  // Result action codes
  localparam logic [ActionW-1:0] ACT_HOLD     = 3'd0;
  localparam logic [ActionW-1:0] ACT_BUY      = 3'd1;
  localparam logic [ActionW-1:0] ACT_SELL     = 3'd2;
  localparam logic [ActionW-1:0] ACT_SQ_LONG  = 3'd3;
  localparam logic [ActionW-1:0] ACT_SQ_SHORT = 3'd4;
  localparam logic [ActionW-1:0] ACT_SQ_FLAT  = 3'd5;

  typedef struct packed {
    logic [PriceW-1:0] close_price;
    logic [DayW-1:0]   day_tag;
    logic              first_day;
    logic              last_day;
  } in_item_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [AmountW-1:0] amount;
    logic [DayW-1:0]    day_out;
    logic               last_result;
  } out_item_t;

  // Commands from the sequencer to the shared multiplier
  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add_hi;
    logic rnd_en;
  } mul_cmd_t;

  typedef enum logic [1:0] {
    JOB_FAST = 2'd0,
    JOB_SLOW = 2'd1,
    JOB_SIG  = 2'd2
  } job_e;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DIFF   = 12'b0000_0000_0010,
    S_MLO    = 12'b0000_0000_0100,
    S_MHI    = 12'b0000_0000_1000,
    S_ACC    = 12'b0000_0001_0000,
    S_RND    = 12'b0000_0010_0000,
    S_UPD    = 12'b0000_0100_0000,
    S_MACD   = 12'b0000_1000_0000,
    S_DECIDE = 12'b0001_0000_0000,
    S_SQ_MUL = 12'b0010_0000_0000,
    S_SQ_OUT = 12'b0100_0000_0000,
    S_SPARE  = 12'b1000_0000_0000
  } state_e;

endpackage

FILE: hdl/mcs_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface mcs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/mcs_mul_unit.sv
// Shared 32x32 multiplier with wide accumulator and round-to-nearest scaling.
module mcs_mul_unit #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                    clk_i,
  input  mcs_pkg::mul_cmd_t       cmd_i,
  input  logic [mcs_pkg::MulW-1:0] op_a_i,
  input  logic [mcs_pkg::MulW-1:0] op_b_i,
  output logic [mcs_pkg::ProdW-1:0] prod_o,
  output logic [mcs_pkg::AvgW-1:0]  rnd_o
);
  import mcs_pkg::*;

  localparam logic [AccW-1:0] Half = AccW'(1) << (COEF_FRAC_BITS - 1);

  logic [ProdW-1:0] prod_q;
  logic [AccW-1:0]  acc_q;
  logic [AccW-1:0]  acc_d;
  logic [AccW-1:0]  rnd_sum;
  logic [AvgW-1:0]  rnd_q;

  // Load the low partial product, or add the high one shifted up a word
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_load) begin
      acc_d = {{(AccW - ProdW){1'b0}}, prod_q};
    end else if (cmd_i.acc_add_hi) begin
      acc_d = acc_q + {prod_q[AccW-MulW-1:0], {MulW{1'b0}}};
    end
  end

  assign rnd_sum = acc_q + Half;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
    acc_q <= acc_d;
    if (cmd_i.rnd_en) begin
      rnd_q <= rnd_sum[COEF_FRAC_BITS+AvgW-1:COEF_FRAC_BITS];
    end
  end

  assign prod_o = prod_q;
  assign rnd_o  = rnd_q;

endmodule

FILE: hdl/macd_crossover_signal_unit.sv
// MACD 12/26/9 crossover trader: top level with sequencer, state and output register.
//
// Input channel in_i carries one closing price (Q16.16) per transfer with a day tag
// and first_day/last_day flags. Output channel out_o carries trade results: one per
// day, plus a square-off result after a last day (last_result marks the final one).
// Users must write max_position (cfg_we_i/cfg_data_i) only while idle (unenforced).
//
// All arithmetic runs through one shared 32x32 multiplier. Each of the three
// exponential averages steps through difference, two partial products,
// accumulate, round and update, and the averages are done one after another.
// The block takes a new item only after it is done with the previous one. A
// first day seeds the averages and goes straight to the decision, and a last day
// adds a square-off product step. Input ready is high only while idle.
//
// Results wait in a single output register; the sequencer stalls in place while
// it is full and the receiver holds ready low, so nothing is lost or repeated.
// Reset clears the averages, MACD, position and channels; max_position resets
// to 1.
module macd_crossover_signal_unit #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mcs_pkg::MaxPosW-1:0] cfg_data_i,
  mcs_stream_if.sink                  in_i,
  mcs_stream_if.source                out_o
);
  import mcs_pkg::*;

  // Coefficients, rounded to nearest
  localparam logic [63:0] AlphaFastW =
    ((64'd1 << (COEF_FRAC_BITS + 2)) + 64'd13) / 64'd26;
  localparam logic [63:0] AlphaSlowW =
    ((64'd1 << (COEF_FRAC_BITS + 2)) + 64'd27) / 64'd54;
  localparam logic [63:0] AlphaSigW =
    ((64'd1 << (COEF_FRAC_BITS + 1)) + 64'd5) / 64'd10;
  localparam logic [MulW-1:0] AlphaFast = AlphaFastW[MulW-1:0];
  localparam logic [MulW-1:0] AlphaSlow = AlphaSlowW[MulW-1:0];
  localparam logic [MulW-1:0] AlphaSig  = AlphaSigW[MulW-1:0];

  state_e              state_q, state_d;
  job_e                job_q, job_d;
  logic [PriceW-1:0]   close_q, close_d;
  logic [DayW-1:0]     day_q, day_d;
  logic                last_q, last_d;
  logic [AvgW-1:0]     fast_q, fast_d;
  logic [AvgW-1:0]     slow_q, slow_d;
  logic [AvgW-1:0]     sig_q, sig_d;
  logic [AvgW-1:0]     macd_q, macd_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [AvgW-1:0]     mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [MaxPosW-1:0]  max_pos_q, max_pos_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                in_ready;
  logic                slot_free;
  logic [AvgW-1:0]     px_in;
  logic [AvgW-1:0]     cur_avg;
  logic [AvgW-1:0]     cur_x;
  logic [MulW-1:0]     alpha_sel;
  logic [AvgW-1:0]     diff;
  logic [AvgW-1:0]     ndiff;
  logic [AvgW-1:0]     upd;
  logic [PosW-1:0]     lim;
  logic [PosW-1:0]     pos_inv;
  logic [MaxPosW-1:0]  pos_mag;
  logic                macd_gt;
  logic                macd_lt;
  logic                can_buy;
  logic                can_sell;
  logic [ActionW-1:0]  sq_action;

  mul_cmd_t            mul_cmd;
  logic [MulW-1:0]     mul_a;
  logic [MulW-1:0]     mul_b;
  logic [ProdW-1:0]    prod;
  logic [AvgW-1:0]     rnd;

  mcs_mul_unit #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .cmd_i  (mul_cmd),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod),
    .rnd_o  (rnd)
  );

  // Price widened to the average format
  assign px_in = {{(AvgW - PriceW - PriceShift){1'b0}}, in_i.payload.close_price,
                  {PriceShift{1'b0}}};

  // Select the operands of the running average job
  always_comb begin
    case (job_q)
      JOB_FAST: begin
        cur_avg   = fast_q;
        cur_x     = {{(AvgW - PriceW - PriceShift){1'b0}}, close_q, {PriceShift{1'b0}}};
        alpha_sel = AlphaFast;
      end
      JOB_SLOW: begin
        cur_avg   = slow_q;
        cur_x     = {{(AvgW - PriceW - PriceShift){1'b0}}, close_q, {PriceShift{1'b0}}};
        alpha_sel = AlphaSlow;
      end
      default: begin
        cur_avg   = sig_q;
        cur_x     = macd_q;
        alpha_sel = AlphaSig;
      end
    endcase
  end

  assign diff  = cur_x - cur_avg;
  assign ndiff = cur_avg - cur_x;
  assign upd   = neg_q ? (cur_avg - rnd) : (cur_avg + rnd);

  // Crossover and position limit checks
  assign lim      = {1'b0, max_pos_q};
  assign macd_gt  = $signed(macd_q) > $signed(sig_q);
  assign macd_lt  = $signed(macd_q) < $signed(sig_q);
  assign can_buy  = $signed(pos_q) < $signed(lim);
  assign can_sell = $signed(pos_q) > -$signed(lim);
  assign pos_inv  = {PosW{1'b0}} - pos_q;
  assign pos_mag  = pos_q[PosW-1] ? pos_inv[MaxPosW-1:0] : pos_q[MaxPosW-1:0];

  always_comb begin
    if (pos_q[PosW-1]) begin
      sq_action = ACT_SQ_SHORT;
    end else if (pos_q != '0) begin
      sq_action = ACT_SQ_LONG;
    end else begin
      sq_action = ACT_SQ_FLAT;
    end
  end

  assign slot_free = !out_valid_q || out_o.ready;

  // Drive the shared multiplier
  always_comb begin
    mul_cmd = '0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      S_MLO: begin
        mul_cmd.mul_en = 1'b1;
        mul_a          = mag_q[MulW-1:0];
        mul_b          = alpha_sel;
      end
      S_MHI: begin
        mul_cmd.mul_en   = 1'b1;
        mul_cmd.acc_load = 1'b1;
        mul_a            = {{(2 * MulW - AvgW){1'b0}}, mag_q[AvgW-1:MulW]};
        mul_b            = alpha_sel;
      end
      S_ACC: begin
        mul_cmd.acc_add_hi = 1'b1;
      end
      S_RND: begin
        mul_cmd.rnd_en = 1'b1;
      end
      S_SQ_MUL: begin
        mul_cmd.mul_en = 1'b1;
        mul_a          = close_q;
        mul_b          = {{(MulW - MaxPosW){1'b0}}, pos_mag};
      end
      default: begin
        mul_cmd = '0;
      end
    endcase
  end

  // Sequencer and next state of the datapath
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    close_d     = close_q;
    day_d       = day_q;
    last_d      = last_q;
    fast_d      = fast_q;
    slow_d      = slow_q;
    sig_d       = sig_q;
    macd_d      = macd_q;
    pos_d       = pos_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    in_ready    = 1'b0;
    max_pos_d   = cfg_we_i ? cfg_data_i : max_pos_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          close_d = in_i.payload.close_price;
          day_d   = in_i.payload.day_tag;
          last_d  = in_i.payload.last_day;
          if (in_i.payload.first_day) begin
            fast_d  = px_in;
            slow_d  = px_in;
            sig_d   = '0;
            macd_d  = '0;
            pos_d   = '0;
            state_d = S_DECIDE;
          end else begin
            job_d   = JOB_FAST;
            state_d = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        neg_d   = diff[AvgW-1];
        mag_d   = diff[AvgW-1] ? ndiff : diff;
        state_d = S_MLO;
      end
      S_MLO: state_d = S_MHI;
      S_MHI: state_d = S_ACC;
      S_ACC: state_d = S_RND;
      S_RND: state_d = S_UPD;
      S_UPD: begin
        case (job_q)
          JOB_FAST: begin
            fast_d  = upd;
            job_d   = JOB_SLOW;
            state_d = S_DIFF;
          end
          JOB_SLOW: begin
            slow_d  = upd;
            state_d = S_MACD;
          end
          default: begin
            sig_d   = upd;
            state_d = S_DECIDE;
          end
        endcase
      end
      S_MACD: begin
        macd_d  = fast_q - slow_q;
        job_d   = JOB_SIG;
        state_d = S_DIFF;
      end
      S_DECIDE: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.day_out     = day_q;
          out_d.last_result = !last_q;
          if (macd_gt && can_buy) begin
            out_d.action = ACT_BUY;
            out_d.amount = {{(AmountW - PriceW){1'b0}}, close_q};
            pos_d        = pos_q + PosW'(1);
          end else if (macd_lt && can_sell) begin
            out_d.action = ACT_SELL;
            out_d.amount = {{(AmountW - PriceW){1'b0}}, close_q};
            pos_d        = pos_q - PosW'(1);
          end else begin
            out_d.action = ACT_HOLD;
            out_d.amount = '0;
          end
          state_d = last_q ? S_SQ_MUL : S_IDLE;
        end
      end
      S_SQ_MUL: state_d = S_SQ_OUT;
      S_SQ_OUT: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.action      = sq_action;
          out_d.amount      = prod[AmountW-1:0];
          out_d.day_out     = '0;
          out_d.last_result = 1'b1;
          pos_d             = '0;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= JOB_FAST;
      fast_q      <= '0;
      slow_q      <= '0;
      sig_q       <= '0;
      macd_q      <= '0;
      pos_q       <= '0;
      max_pos_q   <= MaxPosW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      fast_q      <= fast_d;
      slow_q      <= slow_d;
      sig_q       <= sig_d;
      macd_q      <= macd_d;
      pos_q       <= pos_d;
      max_pos_q   <= max_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    close_q <= close_d;
    day_q   <= day_d;
    last_q  <= last_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    out_q   <= out_d;
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

FILE: hdl/mcs_checker.sv
// Port-level checks of the MACD crossover unit, bound to its top level.
`include "macd_crossover_signal_unit_defines.svh"

module mcs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mcs_pkg::ActionW-1:0] out_action_i,
  input logic [mcs_pkg::AmountW-1:0] out_amount_i,
  input logic [mcs_pkg::DayW-1:0]    out_day_i,
  input logic                        out_last_i
);
  import mcs_pkg::*;

  // Hold a stalled result
  `MCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_action_i) && $stable(out_amount_i), "stalled result changed")

  // Take one item at a time: no transfer right after a transfer
  `MCS_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input ready right after a transfer")

  // A result that is not the last of its item is a day trade
  `MCS_ASSERT_NOW(a_day_result, clk_i, rst_ni, out_valid_i && !out_last_i |-> (out_action_i == ACT_HOLD || out_action_i == ACT_BUY || out_action_i == ACT_SELL), "square-off before final result")

  // A square-off is final and carries no day tag
  `MCS_ASSERT_NOW(a_sq_final, clk_i, rst_ni, out_valid_i && (out_action_i == ACT_SQ_LONG || out_action_i == ACT_SQ_SHORT || out_action_i == ACT_SQ_FLAT) |-> out_last_i && (out_day_i == '0), "bad square-off result")

  // A hold moves no money
  `MCS_ASSERT_NOW(a_hold_zero, clk_i, rst_ni, out_valid_i && (out_action_i == ACT_HOLD) |-> (out_amount_i == '0), "hold with nonzero amount")

endmodule

bind macd_crossover_signal_unit mcs_checker u_mcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_action_i (out_o.payload.action),
  .out_amount_i (out_o.payload.amount),
  .out_day_i    (out_o.payload.day_out),
  .out_last_i   (out_o.payload.last_result)
);
